// ===== src/pmpc_pkg.sv =====
// pmpc_pkg: types, constants and helper functions for the memory protection check block
// no dependencies
package pmpc_pkg;

	localparam int NumEntries = 16;
	localparam int IdxW = $clog2(NumEntries);

	localparam logic [2:0] OP_CHECK = 3'd0;
	localparam logic [2:0] OP_WCFG = 3'd1;
	localparam logic [2:0] OP_RCFG = 3'd2;
	localparam logic [2:0] OP_WADDR = 3'd3;
	localparam logic [2:0] OP_RADDR = 3'd4;

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_TOR = 2'd1;
	localparam logic [1:0] MODE_NA4 = 2'd2;
	localparam logic [1:0] MODE_NAPOT = 2'd3;
	localparam logic [1:0] PRIV_MACHINE = 2'd3;
	localparam int LockBit = 7;

	// one classified operation handed from front to back
	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] csr_index;
		logic [31:0] write_data;
		logic [33:0] start;
		logic [33:0] stop;
		logic [2:0] req_perms;
		logic machine;
	} op_t;

	typedef struct packed {
		logic allowed;
		logic [31:0] read_data;
	} res_t;

	// mode field of a config byte
	function automatic logic [1:0] mode_of(input logic [7:0] cfg);
		mode_of = cfg[4:3];
	endfunction

endpackage

// ===== src/pmpc_fifo.sv =====
// pmpc_fifo: two-entry queue of classified operations between front and back
// depends on pmpc_pkg
module pmpc_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input pmpc_pkg::op_t din,
	output logic full,
	input logic pop,
	output logic empty,
	output pmpc_pkg::op_t dout
);
	pmpc_pkg::op_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= din;
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

// ===== src/pmpc_front.sv =====
// pmpc_front: accepts words, computes the access byte range and privilege class
// depends on pmpc_pkg
module pmpc_front (
	input logic [2:0] opcode,
	input logic [3:0] csr_index,
	input logic [31:0] write_data,
	input logic [31:0] access_addr,
	input logic [3:0] access_size,
	input logic [2:0] req_perms,
	input logic [1:0] priv_mode,
	output pmpc_pkg::op_t op
);
	logic [3:0] sz;

	// zero size counts as one byte, end kept unwrapped
	always_comb begin
		sz = (access_size == 4'd0) ? 4'd1 : access_size;
		op.opcode = opcode;
		op.csr_index = csr_index;
		op.write_data = write_data;
		op.start = {2'b00, access_addr};
		op.stop = {2'b00, access_addr} + 34'(sz) - 34'd1;
		op.req_perms = req_perms;
		op.machine = priv_mode == pmpc_pkg::PRIV_MACHINE;
	end
endmodule

// ===== src/pmpc_back.sv =====
// pmpc_back: entry state, csr access and registered two-step access check
// depends on pmpc_pkg
module pmpc_back (
	input logic clk,
	input logic arst_n,
	input logic op_valid,
	input pmpc_pkg::op_t op,
	output logic op_pop,
	output logic res_valid,
	output pmpc_pkg::res_t res,
	input logic res_ready
);
	localparam int N = pmpc_pkg::NumEntries;
	localparam int W = pmpc_pkg::IdxW;

	logic [7:0] cfg_q [N];
	logic [31:0] addr_q [N];

	// stage one: per-entry hit and partial hit
	logic busy_q;
	logic [N-1:0] full_s1, part_s1;
	logic any_s1;
	pmpc_pkg::op_t op_s1;
	logic out_v_q;
	pmpc_pkg::res_t res_q;

	logic [N-1:0] full_c, part_c;
	logic any_c;
	logic [33:0] lo_c [N];
	logic [33:0] hi_c [N];
	logic en_c [N];
	logic [31:0] nap_c [N];

	logic start_ok;
	assign start_ok = op_valid && !busy_q && (!out_v_q || res_ready);
	assign op_pop = start_ok;

	// region bounds and overlap per entry
	always_comb begin
		any_c = 1'b0;
		for (int e = 0; e < N; e++) begin
			logic [34:0] ext;
			ext = 35'd0;
			nap_c[e] = addr_q[e] & ~(addr_q[e] + 32'd1);
			any_c = any_c | (pmpc_pkg::mode_of(cfg_q[e]) != pmpc_pkg::MODE_OFF);
			lo_c[e] = '0;
			hi_c[e] = '0;
			en_c[e] = 1'b0;
			unique case (pmpc_pkg::mode_of(cfg_q[e]))
				pmpc_pkg::MODE_TOR: begin
					lo_c[e] = (e > 0) ? {addr_q[(e > 0) ? e - 1 : 0], 2'b00} : 34'd0;
					hi_c[e] = {addr_q[e], 2'b00} - 34'd1;
					en_c[e] = {addr_q[e], 2'b00} > lo_c[e];
				end
				pmpc_pkg::MODE_NA4: begin
					lo_c[e] = {addr_q[e], 2'b00};
					hi_c[e] = {addr_q[e], 2'b11};
					en_c[e] = 1'b1;
				end
				pmpc_pkg::MODE_NAPOT: begin
					// trailing ones form the mask; all ones covers everything
					ext = {1'b0, addr_q[e], 2'b11} | {nap_c[e], 3'b111};
					lo_c[e] = {addr_q[e] & ~nap_c[e], 2'b00};
					hi_c[e] = (&addr_q[e]) ? {34{1'b1}} : ext[33:0];
					en_c[e] = 1'b1;
				end
				default: en_c[e] = 1'b0;
			endcase
			full_c[e] = en_c[e] && op.start >= lo_c[e] && op.stop <= hi_c[e];
			part_c[e] = en_c[e] && !(op.start > hi_c[e] || op.stop < lo_c[e]);
		end
	end

	// stage two: priority pick and result
	pmpc_pkg::res_t r_c;
	always_comb begin
		logic done;
		logic [2:0] g;
		done = 1'b0;
		g = 3'b000;
		r_c = '0;
		unique case (op_s1.opcode)
			pmpc_pkg::OP_CHECK: begin
				r_c.allowed = !any_s1 ? 1'b1 : op_s1.machine;
				for (int e = 0; e < N; e++) begin
					if (!done && part_s1[e]) begin
						done = 1'b1;
						g = (op_s1.machine && !cfg_q[e][pmpc_pkg::LockBit]) ? 3'b111
							: cfg_q[e][2:0];
						r_c.allowed = full_s1[e] && ((op_s1.req_perms & g) == op_s1.req_perms);
					end
				end
				if (!any_s1) r_c.allowed = 1'b1;
			end
			pmpc_pkg::OP_RCFG: begin
				for (int i = 0; i < 4; i++)
					if (32'(op_s1.csr_index) * 4 + i < N)
						r_c.read_data[8*i +: 8] =
							cfg_q[W'(32'(op_s1.csr_index) * 4 + i)];
			end
			pmpc_pkg::OP_RADDR: begin
				if (32'(op_s1.csr_index) < N) r_c.read_data = addr_q[W'(op_s1.csr_index)];
			end
			default: r_c = '0;
		endcase
	end

	// entry state writes happen at stage two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < N; e++) begin
				cfg_q[e] <= 8'd0;
				addr_q[e] <= 32'd0;
			end
		end else if (busy_q) begin
			if (op_s1.opcode == pmpc_pkg::OP_WCFG) begin
				for (int i = 0; i < 4; i++)
					if (32'(op_s1.csr_index) * 4 + i < N)
						if (!cfg_q[W'(32'(op_s1.csr_index) * 4 + i)][pmpc_pkg::LockBit])
							cfg_q[W'(32'(op_s1.csr_index) * 4 + i)] <=
								op_s1.write_data[8*i +: 8];
			end else if (op_s1.opcode == pmpc_pkg::OP_WADDR) begin
				for (int e = 0; e < N; e++)
					if (32'(op_s1.csr_index) == e && !cfg_q[e][pmpc_pkg::LockBit] &&
						!(e + 1 < N && cfg_q[(e + 1 < N) ? e + 1 : e][pmpc_pkg::LockBit] &&
						pmpc_pkg::mode_of(cfg_q[(e + 1 < N) ? e + 1 : e]) ==
						pmpc_pkg::MODE_TOR))
						addr_q[e] <= op_s1.write_data;
			end
		end
	end

	// stage one registers
	always_ff @(posedge clk) begin
		if (start_ok) begin
			op_s1 <= op;
			full_s1 <= full_c;
			part_s1 <= part_c;
			any_s1 <= any_c;
		end
		if (busy_q) res_q <= r_c;
	end

	// control: one op in flight, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			busy_q <= start_ok;
			if (busy_q) out_v_q <= 1'b1;
			else if (res_ready) out_v_q <= 1'b0;
		end
	end

	assign res_valid = out_v_q;
	assign res = res_q;

	a_busy_room: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !out_v_q || res_ready || $past(res_ready)) else $error("overrun");
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start_ok) else $error("two in flight");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> out_v_q) else $error("result lost");
endmodule

// ===== src/physical_memory_protection_check.sv =====
// physical_memory_protection_check: top level of the memory protection unit
// depends on pmpc_pkg, pmpc_front, pmpc_fifo, pmpc_back
//
// Each word passes through the back end in order: first the sixteen parallel
// region compares, then the lowest-entry priority pick and csr update. The
// front classifies words into a two-deep queue, so a new word is taken while a
// result waits in the output register; the back end takes one word at a time.
module physical_memory_protection_check (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode[2:0] csr_index[6:3] write_data[38:7] access_addr[70:39]
	// access_size[74:71] req_perms[77:75] priv_mode[79:78]
	input logic [79:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// allowed[0] read_data[32:1]
	output logic [39:0] m_axis_tdata
);
	pmpc_pkg::op_t op_in, op_q;
	pmpc_pkg::res_t res;
	logic full, empty, pop;

	pmpc_front u_front (
		.opcode(s_axis_tdata[2:0]), .csr_index(s_axis_tdata[6:3]),
		.write_data(s_axis_tdata[38:7]), .access_addr(s_axis_tdata[70:39]),
		.access_size(s_axis_tdata[74:71]), .req_perms(s_axis_tdata[77:75]),
		.priv_mode(s_axis_tdata[79:78]), .op(op_in)
	);

	assign s_axis_tready = !full;

	pmpc_fifo u_fifo (
		.clk, .arst_n, .push(s_axis_tvalid), .din(op_in), .full,
		.pop, .empty, .dout(op_q)
	);

	pmpc_back u_back (
		.clk, .arst_n, .op_valid(!empty), .op(op_q), .op_pop(pop),
		.res_valid(m_axis_tvalid), .res, .res_ready(m_axis_tready)
	);

	// pack result word
	assign m_axis_tdata = {7'd0, res.read_data, res.allowed};
endmodule
